// ===== sv/ik4_pkg.sv =====
package ik4_pkg;

    localparam int FRONT_LAT  = 8;
    localparam int SQRT_CELLS = 32;
    localparam int POST_LAT   = 2;
    localparam int ATAN_FIXED = 14;
    localparam int XY_W       = 34;
    localparam int Z_W        = 35;

    localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] Z_HALF = 35'sd65536;

    localparam logic signed [Z_W-1:0] ATAN_Q30 [10] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149
    };

    typedef struct packed {
        logic               ls;
        logic signed [31:0] a0;
        logic signed [31:0] a1;
        logic signed [63:0] a0b;
        logic signed [63:0] a1b;
    } t_side;

    function automatic logic signed [Z_W-1:0] atan_step(input int idx);
        logic signed [Z_W-1:0] v;
        v = '0;
        if (idx < 10) begin
            v = ATAN_Q30[idx[3:0]];
        end else if (idx <= 30) begin
            v[30-idx] = 1'b1;
        end
        return v;
    endfunction

endpackage

// ===== sv/ik4_front.sv =====
module ik4_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [23:0]  i_point_x,
    input  logic signed [23:0]  i_point_y,
    input  logic signed [23:0]  i_point_z,
    input  logic signed [15:0]  i_axis_x,
    input  logic signed [15:0]  i_axis_y,
    input  logic signed [15:0]  i_axis_z,
    input  logic signed [15:0]  i_dir_x,
    input  logic signed [15:0]  i_dir_y,
    input  logic signed [15:0]  i_dir_z,
    input  logic signed [23:0]  i_target,
    output logic                o_valid,
    output logic [63:0]         o_rad,
    output ik4_pkg::t_side      o_side
);

    localparam int NL = ik4_pkg::FRONT_LAT;

    logic signed [15:0] w_k [3];
    logic signed [15:0] w_h [3];
    logic signed [23:0] w_p [3];

    assign w_k[0] = i_axis_x;
    assign w_k[1] = i_axis_y;
    assign w_k[2] = i_axis_z;
    assign w_h[0] = i_dir_x;
    assign w_h[1] = i_dir_y;
    assign w_h[2] = i_dir_z;
    assign w_p[0] = i_point_x;
    assign w_p[1] = i_point_y;
    assign w_p[2] = i_point_z;

    logic [NL-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NL-2:0], i_valid};
        end
    end

    logic signed [39:0] r1_m0 [3];
    logic signed [39:0] r1_m1 [3];
    logic signed [39:0] r1_kp [3];
    logic signed [31:0] r1_hk [3];
    logic signed [15:0] r1_k [3];
    logic signed [15:0] r1_h [3];
    logic signed [23:0] r1_d;

    logic signed [27:0] r2_c [3];
    logic signed [15:0] r2_k [3];
    logic signed [15:0] r2_h [3];
    logic signed [27:0] r2_kp;
    logic signed [33:0] r2_hk;
    logic signed [23:0] r2_d;

    logic signed [43:0] r3_m0 [3];
    logic signed [43:0] r3_m1 [3];
    logic signed [43:0] r3_ha [3];
    logic signed [15:0] r3_h [3];
    logic signed [61:0] r3_hkkp;
    logic signed [23:0] r3_d;

    logic signed [29:0] r4_e [3];
    logic signed [15:0] r4_h [3];
    logic signed [31:0] r4_a0;
    logic signed [31:0] r4_b;

    logic signed [45:0] r5_he [3];
    logic signed [31:0] r5_a0;
    logic signed [31:0] r5_b;

    logic signed [31:0] r6_a0;
    logic signed [31:0] r6_a1;
    logic signed [31:0] r6_b;

    logic signed [63:0] r7_a0sq;
    logic signed [63:0] r7_a1sq;
    logic signed [63:0] r7_bb;
    logic signed [63:0] r7_a0b;
    logic signed [63:0] r7_a1b;
    logic signed [31:0] r7_a0;
    logic signed [31:0] r7_a1;

    logic [63:0]        r8_rad;
    ik4_pkg::t_side     r8_side;

    for (genvar g = 0; g < 3; g++) begin : g_vec
        localparam int G1 = (g + 1) % 3;
        localparam int G2 = (g + 2) % 3;

        logic signed [41:0] w_cd;
        logic signed [44:0] w_ed;

        assign w_cd = 42'(r1_m0[g]) - 42'(r1_m1[g]) + 42'sd8192;
        assign w_ed = 45'(r3_m0[g]) - 45'(r3_m1[g]) + 45'sd8192;

        always_ff @(posedge i_clk) begin
            r1_m0[g] <= w_k[G1] * w_p[G2];
            r1_m1[g] <= w_k[G2] * w_p[G1];
            r1_kp[g] <= w_k[g] * w_p[g];
            r1_hk[g] <= w_h[g] * w_k[g];
            r1_k[g]  <= w_k[g];
            r1_h[g]  <= w_h[g];
            r2_c[g]  <= w_cd[41:14];
            r2_k[g]  <= r1_k[g];
            r2_h[g]  <= r1_h[g];
            r3_m0[g] <= r2_k[G1] * r2_c[G2];
            r3_m1[g] <= r2_k[G2] * r2_c[G1];
            r3_ha[g] <= r2_h[g] * r2_c[g];
            r3_h[g]  <= r2_h[g];
            r4_e[g]  <= w_ed[43:14];
            r4_h[g]  <= r3_h[g];
            r5_he[g] <= r4_h[g] * r4_e[g];
        end
    end

    logic signed [41:0] w_ks;
    logic signed [45:0] w_as;
    logic signed [61:0] w_q;
    logic signed [31:0] w_qs;
    logic signed [47:0] w_es;
    logic signed [31:0] w_a1p;
    logic signed [63:0] w_norm;
    logic               w_gt;

    assign w_ks   = 42'(r1_kp[0]) + 42'(r1_kp[1]) + 42'(r1_kp[2]) + 42'sd8192;
    assign w_as   = 46'(r3_ha[0]) + 46'(r3_ha[1]) + 46'(r3_ha[2]) + 46'sd8192;
    assign w_q    = r3_hkkp + 62'sd134217728;
    assign w_qs   = w_q[59:28];
    assign w_es   = 48'(r5_he[0]) + 48'(r5_he[1]) + 48'(r5_he[2]) + 48'sd8192;
    assign w_a1p  = w_es[45:14];
    assign w_norm = r7_a0sq + r7_a1sq;
    assign w_gt   = w_norm > r7_bb;

    always_ff @(posedge i_clk) begin
        r1_d    <= i_target;
        r2_kp   <= w_ks[41:14];
        r2_hk   <= 34'(r1_hk[0]) + 34'(r1_hk[1]) + 34'(r1_hk[2]);
        r2_d    <= r1_d;
        r3_hkkp <= r2_hk * r2_kp;
        r3_d    <= r2_d;
        r4_a0   <= w_as[45:14];
        r4_b    <= 32'(r3_d) - w_qs;
        r5_a0   <= r4_a0;
        r5_b    <= r4_b;
        r6_a0   <= r5_a0;
        r6_a1   <= -w_a1p;
        r6_b    <= r5_b;
        r7_a0sq <= r6_a0 * r6_a0;
        r7_a1sq <= r6_a1 * r6_a1;
        r7_bb   <= r6_b * r6_b;
        r7_a0b  <= r6_a0 * r6_b;
        r7_a1b  <= r6_a1 * r6_b;
        r7_a0   <= r6_a0;
        r7_a1   <= r6_a1;
        // tangent case counts as least squares
        r8_rad      <= w_gt ? 64'(w_norm - r7_bb) : 64'd0;
        r8_side.ls  <= !w_gt;
        r8_side.a0  <= r7_a0;
        r8_side.a1  <= r7_a1;
        r8_side.a0b <= r7_a0b;
        r8_side.a1b <= r7_a1b;
    end

    assign o_valid = r_vld[NL-1];
    assign o_rad   = r8_rad;
    assign o_side  = r8_side;

endmodule

// ===== sv/ik4_sqrt_cell.sv =====
module ik4_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [63:0]    i_rem,
    input  logic [63:0]    i_root,
    input  ik4_pkg::t_side i_side,
    output logic           o_valid,
    output logic [63:0]    o_rem,
    output logic [63:0]    o_root,
    output ik4_pkg::t_side o_side
);

    localparam logic [63:0] STEP_BIT = 64'd1 << BIT_POS;

    logic [63:0] w_trial;
    logic        w_take;

    assign w_trial = i_root + STEP_BIT;
    assign w_take  = i_rem >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= w_take ? i_rem - w_trial : i_rem;
        o_root <= w_take ? (i_root >> 1) + STEP_BIT : i_root >> 1;
        o_side <= i_side;
    end

endmodule

// ===== sv/ik4_cordic_cell.sv =====
module ik4_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  logic signed [ik4_pkg::XY_W-1:0]   i_x,
    input  logic signed [ik4_pkg::XY_W-1:0]   i_y,
    input  logic signed [ik4_pkg::Z_W-1:0]    i_z,
    output logic signed [ik4_pkg::XY_W-1:0]   o_x,
    output logic signed [ik4_pkg::XY_W-1:0]   o_y,
    output logic signed [ik4_pkg::Z_W-1:0]    o_z
);

    localparam logic signed [ik4_pkg::Z_W-1:0] STEP = ik4_pkg::atan_step(IDX);

    logic signed [ik4_pkg::XY_W-1:0] w_dx;
    logic signed [ik4_pkg::XY_W-1:0] w_dy;

    assign w_dx = i_x >>> IDX;
    assign w_dy = i_y >>> IDX;

    always_ff @(posedge i_clk) begin
        if (i_y > 0) begin
            o_x <= i_x + w_dy;
            o_y <= i_y - w_dx;
            o_z <= i_z + STEP;
        end else if (i_y < 0) begin
            o_x <= i_x - w_dy;
            o_y <= i_y + w_dx;
            o_z <= i_z - STEP;
        end else begin
            // on the axis: hold
            o_x <= i_x;
            o_y <= i_y;
            o_z <= i_z;
        end
    end

endmodule

// ===== sv/ik4_atan.sv =====
module ik4_atan #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ls,
    input  logic signed [63:0] i_y [2],
    input  logic signed [63:0] i_x [2],
    output logic               o_valid,
    output logic               o_least_squares,
    output logic signed [15:0] o_angle [2]
);

    localparam int LAT = ik4_pkg::ATAN_FIXED + CORDIC_STAGES;
    localparam int NRM = 12;
    localparam int XW  = ik4_pkg::XY_W;
    localparam int ZW  = ik4_pkg::Z_W;

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_ls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ls <= {r_ls[LAT-2:0], i_ls};
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [63:0] r_ax [NRM];
        logic [63:0] r_ay [NRM];
        logic        r_xn [NRM];
        logic        r_yn [NRM];

        always_ff @(posedge i_clk) begin
            r_ax[0] <= i_x[g][63] ? 64'(-i_x[g]) : 64'(i_x[g]);
            r_ay[0] <= i_y[g][63] ? 64'(-i_y[g]) : 64'(i_y[g]);
            r_xn[0] <= i_x[g][63];
            r_yn[0] <= i_y[g][63];
        end

        // bring the larger magnitude into [2^29, 2^30), one shift size a step
        for (genvar k = 1; k < NRM; k++) begin : g_nrm
            logic [63:0] w_m;
            logic        w_sh;

            assign w_m = r_ax[k-1] | r_ay[k-1];

            if (k <= 6) begin : g_right
                localparam int SH = 1 << (6 - k);
                assign w_sh = (w_m >> (29 + SH)) != 64'd0;
                always_ff @(posedge i_clk) begin
                    r_ax[k] <= w_sh ? r_ax[k-1] >> SH : r_ax[k-1];
                    r_ay[k] <= w_sh ? r_ay[k-1] >> SH : r_ay[k-1];
                end
            end else begin : g_left
                localparam int SH = 1 << (11 - k);
                assign w_sh = (w_m >> (30 - SH)) == 64'd0;
                always_ff @(posedge i_clk) begin
                    r_ax[k] <= w_sh ? r_ax[k-1] << SH : r_ax[k-1];
                    r_ay[k] <= w_sh ? r_ay[k-1] << SH : r_ay[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                r_xn[k] <= r_xn[k-1];
                r_yn[k] <= r_yn[k-1];
            end
        end

        logic [29:0]          w_ax;
        logic [29:0]          w_ay;
        logic                 w_fold;
        logic                 w_yneg;
        logic signed [XW-1:0] w_ya;

        assign w_ax   = r_ax[NRM-1][29:0];
        assign w_ay   = r_ay[NRM-1][29:0];
        assign w_fold = r_xn[NRM-1] && (w_ax != 30'd0);
        assign w_yneg = r_yn[NRM-1] && (w_ay != 30'd0);
        assign w_ya   = XW'(w_ay);

        logic signed [XW-1:0] w_cx [CORDIC_STAGES+1];
        logic signed [XW-1:0] w_cy [CORDIC_STAGES+1];
        logic signed [ZW-1:0] w_cz [CORDIC_STAGES+1];
        logic signed [XW-1:0] r_cx0;
        logic signed [XW-1:0] r_cy0;
        logic signed [ZW-1:0] r_cz0;

        // fold the left half plane onto the right, starting from +pi or -pi
        always_ff @(posedge i_clk) begin
            r_cx0 <= XW'(w_ax);
            r_cy0 <= (w_yneg ^ w_fold) ? -w_ya : w_ya;
            if (w_fold) begin
                r_cz0 <= w_yneg ? -ik4_pkg::PI_Q30 : ik4_pkg::PI_Q30;
            end else begin
                r_cz0 <= '0;
            end
        end

        assign w_cx[0] = r_cx0;
        assign w_cy[0] = r_cy0;
        assign w_cz[0] = r_cz0;

        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
            ik4_cordic_cell #(.IDX(s)) u_cell (
                .i_clk (i_clk),
                .i_x   (w_cx[s]),
                .i_y   (w_cy[s]),
                .i_z   (w_cz[s]),
                .o_x   (w_cx[s+1]),
                .o_y   (w_cy[s+1]),
                .o_z   (w_cz[s+1])
            );
        end

        logic signed [ZW-1:0] w_zr;

        assign w_zr = w_cz[CORDIC_STAGES] + ik4_pkg::Z_HALF;

        always_ff @(posedge i_clk) begin
            // second angle reads zero for a least-squares word
            if (g == 1 && r_ls[LAT-2]) begin
                o_angle[g] <= '0;
            end else begin
                o_angle[g] <= w_zr[32:17];
            end
        end
    end

    assign o_valid         = r_vld[LAT-1];
    assign o_least_squares = r_ls[LAT-1];

endmodule

// ===== sv/ik_subproblem4_angle_solver.sv =====
// Angle solver for a point rotated about a unit axis and projected on a unit
// direction: returns the angles at which the projection meets the target.
// Input channel: the ten fields are sampled at a rising edge with start high
// and busy low; busy never rises, so a word may be offered every cycle.
// Output channel: o_done is high for one cycle with o_angle_one, o_angle_two
// and o_least_squares valid in that same cycle. The receiver cannot stall
// the block and must take each word as it appears.
// Throughput: one word in and one word out per cycle. The pipeline is an
// 8-stage multiply front end, a 32-cell square-root chain, two product
// stages, 12 normalize stages, a fold register, the chain of CORDIC_STAGES
// rotation cells and the final rounding register.
// Reset: synchronous, active low; it clears all words in flight and o_done
// stays low until the first accepted word has passed the whole pipeline.
// Words in flight keep their order; none is dropped.
module ik_subproblem4_angle_solver #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic signed [23:0] i_point_z,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  logic signed [23:0] i_target,
    output logic               o_done,
    output logic signed [15:0] o_angle_one,
    output logic signed [15:0] o_angle_two,
    output logic               o_least_squares
);

    localparam int NS  = ik4_pkg::SQRT_CELLS;
    localparam int LAT = ik4_pkg::FRONT_LAT + NS + ik4_pkg::POST_LAT
                         + ik4_pkg::ATAN_FIXED + CORDIC_STAGES;

    logic           w_accept;
    logic           w_fv;
    logic [63:0]    w_rad;
    ik4_pkg::t_side w_fside;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    ik4_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_axis_x  (i_axis_x),
        .i_axis_y  (i_axis_y),
        .i_axis_z  (i_axis_z),
        .i_dir_x   (i_dir_x),
        .i_dir_y   (i_dir_y),
        .i_dir_z   (i_dir_z),
        .i_target  (i_target),
        .o_valid   (w_fv),
        .o_rad     (w_rad),
        .o_side    (w_fside)
    );

    logic           w_sv   [NS+1];
    logic [63:0]    w_rem  [NS+1];
    logic [63:0]    w_root [NS+1];
    ik4_pkg::t_side w_ss   [NS+1];

    assign w_sv[0]   = w_fv;
    assign w_rem[0]  = w_rad;
    assign w_root[0] = '0;
    assign w_ss[0]   = w_fside;

    // one result bit per cell, top bit pair first
    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        ik4_sqrt_cell #(.BIT_POS(62 - 2 * j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sv[j]),
            .i_rem   (w_rem[j]),
            .i_root  (w_root[j]),
            .i_side  (w_ss[j]),
            .o_valid (w_sv[j+1]),
            .o_rem   (w_rem[j+1]),
            .o_root  (w_root[j+1]),
            .o_side  (w_ss[j+1])
        );
    end

    logic signed [32:0] w_xi;

    assign w_xi = {1'b0, w_root[NS][31:0]};

    logic [1:0]         r_pv;
    logic signed [63:0] r_xa0;
    logic signed [63:0] r_xa1;
    logic signed [63:0] r_a0b;
    logic signed [63:0] r_a1b;
    logic               r_ls1;
    logic signed [63:0] r_y [2];
    logic signed [63:0] r_x [2];
    logic               r_ls2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[0], w_sv[NS]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_xa0 <= w_xi * w_ss[NS].a0;
        r_xa1 <= w_xi * w_ss[NS].a1;
        r_a0b <= w_ss[NS].a0b;
        r_a1b <= w_ss[NS].a1b;
        r_ls1 <= w_ss[NS].ls;
        r_y[0] <= r_a0b + r_xa1;
        r_x[0] <= r_a1b - r_xa0;
        r_y[1] <= r_a0b - r_xa1;
        r_x[1] <= r_a1b + r_xa0;
        r_ls2  <= r_ls1;
    end

    logic signed [15:0] w_ang [2];

    ik4_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_pv[1]),
        .i_ls            (r_ls2),
        .i_y             (r_y),
        .i_x             (r_x),
        .o_valid         (o_done),
        .o_least_squares (o_least_squares),
        .o_angle         (w_ang)
    );

    assign o_angle_one = w_ang[0];
    assign o_angle_two = w_ang[1];

    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_done)
        else $error("accepted word did not come out after the pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> ##LAT !o_done)
        else $error("result strobe without an accepted word");

    a_ls_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_least_squares) |-> (o_angle_two == 16'sd0))
        else $error("second angle not zero on a least-squares word");

endmodule

// ===== bench/testbench.sv =====
module testbench;

    localparam int STAGES = 16;
    localparam int LATENCY = 56 + STAGES;

    typedef struct {
        logic signed [23:0] px, py, pz;
        logic signed [15:0] kx, ky, kz;
        logic signed [15:0] hx, hy, hz;
        logic signed [23:0] d;
    } t_problem;

    typedef struct {
        logic signed [15:0] one;
        logic signed [15:0] two;
        logic               ls;
    } t_angles;

    // Floor shift of a signed value.
    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return floor_shift(v + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned acc, bit_w;
        acc = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= acc + bit_w) begin
                v = v - (acc + bit_w);
                acc = (acc >> 1) + bit_w;
            end else begin
                acc = acc >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return longint'(acc);
    endfunction

    function automatic longint step_angle(int i);
        longint tbl [10];
        tbl = '{843314857, 497837829, 263043837, 133525159, 67021687,
                33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return tbl[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic logic signed [15:0] vector_angle(longint y, longint x);
        longint unsigned mx, my;
        longint xs, ys, z, t, dx, dy;
        mx = (x < 0) ? longint'(-x) : x;
        my = (y < 0) ? longint'(-y) : y;
        z = 0;
        if (mx == 0 && my == 0) return 16'sd0;
        while (mx >= (64'd1 << 30) || my >= (64'd1 << 30)) begin
            mx = mx >> 1;
            my = my >> 1;
        end
        while (mx < (64'd1 << 29) && my < (64'd1 << 29)) begin
            mx = mx << 1;
            my = my << 1;
        end
        xs = (x < 0) ? -longint'(mx) : longint'(mx);
        ys = (y < 0) ? -longint'(my) : longint'(my);
        // fold the left half plane onto the right
        if (xs < 0) begin
            z = (ys >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            xs = -xs;
            ys = -ys;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shift(xs, i);
            dy = floor_shift(ys, i);
            if (ys > 0) begin
                t = xs + dy; ys = ys - dx; xs = t; z = z + step_angle(i);
            end else if (ys < 0) begin
                t = xs - dy; ys = ys + dx; xs = t; z = z - step_angle(i);
            end
        end
        return 16'(floor_shift(z + (longint'(1) << 16), 17));
    endfunction

    function automatic t_angles solve_angles(t_problem q);
        longint px, py, pz, kx, ky, kz, hx, hy, hz, d;
        longint cx, cy, cz, ex, ey, ez, a0, a1, kp, hk, b, norm, bb, xi;
        t_angles r;
        px = q.px; py = q.py; pz = q.pz; kx = q.kx; ky = q.ky; kz = q.kz;
        hx = q.hx; hy = q.hy; hz = q.hz; d = q.d;
        cx = round_shift(ky * pz - kz * py, 14);
        cy = round_shift(kz * px - kx * pz, 14);
        cz = round_shift(kx * py - ky * px, 14);
        ex = round_shift(ky * cz - kz * cy, 14);
        ey = round_shift(kz * cx - kx * cz, 14);
        ez = round_shift(kx * cy - ky * cx, 14);
        a0 = round_shift(hx * cx + hy * cy + hz * cz, 14);
        a1 = -round_shift(hx * ex + hy * ey + hz * ez, 14);
        kp = round_shift(kx * px + ky * py + kz * pz, 14);
        hk = hx * kx + hy * ky + hz * kz;
        b = d - round_shift(hk * kp, 28);
        norm = a0 * a0 + a1 * a1;
        bb = b * b;
        if (norm > bb) begin
            xi = int_sqrt(norm - bb);
            r.one = vector_angle(a0 * b + xi * a1, a1 * b - xi * a0);
            r.two = vector_angle(a0 * b - xi * a1, a1 * b + xi * a0);
            r.ls = 1'b0;
        end else begin
            r.one = vector_angle(a0 * b, a1 * b);
            r.two = 16'sd0;
            r.ls = 1'b1;
        end
        return r;
    endfunction

    class angle_board;
        t_angles pending[$];
        int errors = 0;

        function void note_problem(t_problem q);
            pending.push_back(solve_angles(q));
        endfunction

        function void check_word(t_angles got);
            t_angles want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word one=%0d two=%0d ls=%0b",
                         $time, got.one, got.two, got.ls);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.one !== want.one) begin
                $display("%0t: angle_one expected %0d actual %0d",
                         $time, want.one, got.one);
                errors++;
            end
            if (got.two !== want.two) begin
                $display("%0t: angle_two expected %0d actual %0d",
                         $time, want.two, got.two);
                errors++;
            end
            if (got.ls !== want.ls) begin
                $display("%0t: least_squares expected %0b actual %0b",
                         $time, want.ls, got.ls);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy, o_done, o_least_squares;
    logic signed [23:0] i_point_x, i_point_y, i_point_z, i_target;
    logic signed [15:0] i_axis_x, i_axis_y, i_axis_z, i_dir_x, i_dir_y, i_dir_z;
    logic signed [15:0] o_angle_one, o_angle_two;

    angle_board board;

    ik_subproblem4_angle_solver #(.CORDIC_STAGES(STAGES)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_word('{o_angle_one, o_angle_two, o_least_squares});
    end

    // Offer one word and hold it until taken.
    task automatic send_problem(t_problem q);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        {i_point_x, i_point_y, i_point_z} = {q.px, q.py, q.pz};
        {i_axis_x, i_axis_y, i_axis_z} = {q.kx, q.ky, q.kz};
        {i_dir_x, i_dir_y, i_dir_z} = {q.hx, q.hy, q.hz};
        i_target = q.d;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_problem(q);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic logic signed [15:0] unit_comp();
        case ($urandom_range(0, 3))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_problem random_problem();
        t_problem q;
        q.px = 24'($urandom); q.py = 24'($urandom); q.pz = 24'($urandom);
        q.d = 24'($urandom);
        q.kx = 16'($urandom); q.ky = 16'($urandom); q.kz = 16'($urandom);
        q.hx = 16'($urandom); q.hy = 16'($urandom); q.hz = 16'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            // mostly near-unit axes, modest point and target
            q.kx = unit_comp(); q.ky = unit_comp(); q.kz = unit_comp();
            q.hx = unit_comp(); q.hy = unit_comp(); q.hz = unit_comp();
            q.px = q.px >>> $urandom_range(0, 8);
            q.py = q.py >>> $urandom_range(0, 8);
            q.pz = q.pz >>> $urandom_range(0, 8);
            q.d = q.d >>> $urandom_range(0, 12);
        end
        return q;
    endfunction

    initial begin
        t_problem q;
        int idle;
        board = new();
        start = 1'b0;
        i_rst_n = 1'b0;
        {i_point_x, i_point_y, i_point_z, i_target} = '0;
        {i_axis_x, i_axis_y, i_axis_z, i_dir_x, i_dir_y, i_dir_z} = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // all zero: zero vector into atan2
        q = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_problem(q);
        // planar rotation, exact pair
        q = '{65536, 0, 0, 0, 0, 16384, 16384, 0, 0, 32768};
        send_problem(q);
        // target beyond reach: least squares
        q = '{65536, 0, 0, 0, 0, 16384, 16384, 0, 0, 262144};
        send_problem(q);
        // boundary |A|^2 == b^2
        q = '{65536, 0, 0, 0, 0, 16384, 16384, 0, 0, 65536};
        send_problem(q);
        q = '{65536, 0, 0, 0, 0, 16384, 16384, 0, 0, -65536};
        send_problem(q);
        q = '{0, 65536, 0, 0, 0, 16384, 16384, 0, 0, -32768};
        send_problem(q);
        // field extremes
        q = '{-8388608, -8388608, -8388608, -32768, -32768, -32768,
              -32768, -32768, -32768, -8388608};
        send_problem(q);
        q = '{8388607, 8388607, 8388607, 32767, 32767, 32767,
              32767, 32767, 32767, 8388607};
        send_problem(q);
        q = '{8388607, -8388608, 8388607, 32767, -32768, 32767,
              -32768, 32767, -32768, -8388608};
        send_problem(q);
        q = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_problem(q);
        q = '{0, 0, 65536, 16384, 0, 0, 0, 16384, 0, 0};
        send_problem(q);

        for (int n = 0; n < 550; n++) send_problem(random_problem());

        idle = 0;
        while (board.pending.size() != 0 && idle < 20 * LATENCY) begin
            @(posedge i_clk);
            idle++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/ik4_pkg.sv
sv/ik4_front.sv
sv/ik4_sqrt_cell.sv
sv/ik4_cordic_cell.sv
sv/ik4_atan.sv
sv/ik_subproblem4_angle_solver.sv
bench/testbench.sv
